/* rtl/piu_pkg.sv */
// ============================================================================
// piu_pkg
// Types and codes shared by the priority interrupt unit.
// ============================================================================
`default_nettype none

package piu_pkg;

    localparam int unsigned NUM_LEVELS  = 8;
    localparam int unsigned LEVEL_W     = 3;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned VECTOR_W    = 6;
    localparam int unsigned STATUS_ANY  = 3;   // status bit: take any pending level
    localparam logic [BYTE_W-1:0] LINES_RELEASED = 8'hFF;

    typedef enum logic [2:0] {
        ACT_POLL   = 3'd0,
        ACT_RAISE  = 3'd1,
        ACT_DROP   = 3'd2,
        ACT_STATUS = 3'd3,
        ACT_PREAD  = 3'd4,
        ACT_VREAD  = 3'd5
    } piu_action_t;

    typedef struct packed {
        piu_action_t          action;
        logic [LEVEL_W-1:0]   level;
        logic [BYTE_W-1:0]    data;
    } piu_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0]    read_data;
        logic                 cpu_interrupt;
        logic                 fired;
        logic [LEVEL_W-1:0]   fired_level;
    } piu_result_t;

    typedef struct packed {
        logic                 disable_flag;
        logic                 interrupt_line;
        logic [VECTOR_W-1:0]  vector_value;
    } piu_state_t;

endpackage

`default_nettype wire

/* rtl/piu_exec.sv */
// ============================================================================
// piu_exec
// Request/status state and the single-pass logic that handles one item.
// ============================================================================
`default_nettype none

module piu_exec (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                exec_en,
    input  wire piu_pkg::piu_item_t  item,
    output piu_pkg::piu_result_t     result,
    output piu_pkg::piu_state_t      state
);
    import piu_pkg::*;

    logic [BYTE_W-1:0]   req_lines_reg, req_lines_next;
    logic [BYTE_W-1:0]   status_reg, status_next;
    logic                disable_reg, disable_next;
    logic [VECTOR_W-1:0] vector_reg, vector_next;
    logic                int_line_reg, int_line_next;

    logic [BYTE_W-1:0]   pending;
    logic [LEVEL_W-1:0]  top;
    logic                hit;

    // request lines are active low
    assign pending = ~req_lines_reg;

    // priority encode: highest pending level wins
    always_comb
    begin
        top = '0;
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            if (pending[i])
            begin
                top = LEVEL_W'(i);
            end
        end
    end

    assign hit = !disable_reg && (|pending)
                 && (status_reg[STATUS_ANY] || (top > ~status_reg[LEVEL_W-1:0]));

    always_comb
    begin
        req_lines_next = req_lines_reg;
        status_next    = status_reg;
        disable_next   = disable_reg;
        vector_next    = vector_reg;
        int_line_next  = int_line_reg;
        result         = '0;
        case (item.action)
            ACT_POLL:
            begin
                if (hit)
                begin
                    disable_next       = 1'b1;
                    vector_next        = {~top, 3'b000};   // (7 - level) * 8
                    int_line_next      = 1'b1;
                    result.fired       = 1'b1;
                    result.fired_level = top;
                end
            end
            ACT_RAISE:
            begin
                req_lines_next = req_lines_reg & ~(BYTE_W'(1) << item.level);
            end
            ACT_DROP:
            begin
                req_lines_next = req_lines_reg | (BYTE_W'(1) << item.level);
            end
            ACT_STATUS:
            begin
                status_next   = item.data;
                disable_next  = 1'b0;
                int_line_next = 1'b0;
            end
            ACT_PREAD:
            begin
                result.read_data = '0;
            end
            ACT_VREAD:
            begin
                result.read_data = BYTE_W'(vector_reg);
            end
            default:
            begin
            end
        endcase
        result.cpu_interrupt = int_line_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_lines_reg <= LINES_RELEASED;
            status_reg    <= '0;
            disable_reg   <= 1'b0;
            vector_reg    <= '0;
            int_line_reg  <= 1'b0;
        end
        else if (exec_en)
        begin
            req_lines_reg <= req_lines_next;
            status_reg    <= status_next;
            disable_reg   <= disable_next;
            vector_reg    <= vector_next;
            int_line_reg  <= int_line_next;
        end
    end

    assign state.disable_flag   = disable_reg;
    assign state.interrupt_line = int_line_reg;
    assign state.vector_value   = vector_reg;

endmodule

`default_nettype wire

/* rtl/priority_interrupt_unit_core.sv */
// ============================================================================
// priority_interrupt_unit_core
// Eight-level priority interrupt unit with stream in/out channels.
// ============================================================================
`default_nettype none

// One item per clock sustained while the output side accepts results. An accepted
// item is held in the input register, is handled by the single-pass logic in
// piu_exec, and its result is then offered from the output register. Both
// registers advance together, so the input side keeps taking items while a
// result waits, as long as the output register drains.

module priority_interrupt_unit_core (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // level[2:0], data[10:3], zero fill
    input  wire logic [2:0]  s_axis_tuser,   // action[2:0]

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // read_data[7:0], cpu_interrupt[8],
                                             // fired_level[11:9], zero fill
    output logic             m_axis_tuser    // fired
);
    import piu_pkg::*;

    logic        in_valid_reg, in_valid_next;
    piu_item_t   item_reg;
    logic        out_valid_reg, out_valid_next;
    piu_result_t result_reg;

    logic        advance;
    logic        exec_en;
    logic        in_xfer;
    piu_result_t result;
    piu_state_t  state;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign exec_en       = in_valid_reg && advance;

    assign in_valid_next  = s_axis_tready ? s_axis_tvalid : in_valid_reg;
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    piu_exec u_exec (
        .clk     (clk),
        .rst_n   (rst_n),
        .exec_en (exec_en),
        .item    (item_reg),
        .result  (result),
        .state   (state)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            item_reg.action <= piu_action_t'(s_axis_tuser);
            item_reg.level  <= s_axis_tdata[2:0];
            item_reg.data   <= s_axis_tdata[10:3];
        end
        if (exec_en)
        begin
            result_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, result_reg.fired_level,
                            result_reg.cpu_interrupt, result_reg.read_data};
    assign m_axis_tuser  = result_reg.fired;

    // interrupt line and disable flag are always set and cleared together
    a_int_tracks_disable: assert property (@(posedge clk) disable iff (!rst_n)
        state.interrupt_line == state.disable_flag)
        else $error("interrupt line and disable flag disagree");

    // a fired result carries the asserted interrupt
    a_fired_int: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.fired) |-> result_reg.cpu_interrupt)
        else $error("fired result without interrupt");

    // while a fired result is shown, the vector matches its level
    a_fired_vector: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.fired)
            |-> (state.vector_value == {~result_reg.fired_level, 3'b000}))
        else $error("vector does not match fired level");

    // state only moves when an item is handled
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !exec_en |=> $stable(state))
        else $error("state changed without an item");

endmodule

`default_nettype wire

/* dv/priority_interrupt_unit_core_test.sv */
// ============================================================================
// priority_interrupt_unit_core_test
// Stream-level check of the priority interrupt unit. A directed table covers
// reset values, threshold and take-any acceptance, disabled polls and the
// unused action codes. A weighted random item mix follows. Every result is
// compared field by field against the typed expectation of its directed row or
// else an in-bench model of the unit, with random bursts and gaps on the input
// side and random stalls on the output side.
`default_nettype none

module priority_interrupt_unit_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    import piu_pkg::*;

    // action codes the unit must ignore
    localparam logic [2:0] ACT_SPARE_LO = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    localparam int RANDOM_ITEMS = 500;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [2:0]         act;
        logic [LEVEL_W-1:0] lvl;
        logic [BYTE_W-1:0]  din;
        logic               fixed;  // typed expectation in want
        piu_result_t        want;
    } stim_row_t;

    localparam int NUM_DIRECTED = 25;
    localparam piu_result_t R_IDLE = '{8'h00, 1'b0, 1'b0, 3'd0};

    localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
        '{ACT_VREAD,    3'd0, 8'h00, 1'b1, R_IDLE},
        '{ACT_PREAD,    3'd7, 8'hFF, 1'b1, R_IDLE},
        '{ACT_POLL,     3'd0, 8'h00, 1'b1, R_IDLE},
        '{ACT_SPARE_LO, 3'd7, 8'hFF, 1'b1, R_IDLE},
        '{ACT_SPARE_HI, 3'd0, 8'hAA, 1'b1, R_IDLE},
        '{ACT_RAISE,    3'd0, 8'h00, 1'b1, R_IDLE},
        '{ACT_POLL,     3'd0, 8'h00, 1'b1, R_IDLE},  // level 0 not above 7
        '{ACT_STATUS,   3'd0, 8'h08, 1'b1, R_IDLE},
        '{ACT_POLL,     3'd0, 8'h00, 1'b1, '{8'h00, 1'b1, 1'b1, 3'd0}},
        '{ACT_VREAD,    3'd0, 8'h00, 1'b1, '{8'h38, 1'b1, 1'b0, 3'd0}},
        '{ACT_POLL,     3'd0, 8'h00, 1'b0, R_IDLE},  // disabled
        '{ACT_RAISE,    3'd7, 8'h00, 1'b0, R_IDLE},
        '{ACT_STATUS,   3'd0, 8'hFF, 1'b1, R_IDLE},
        '{ACT_POLL,     3'd0, 8'h00, 1'b1, '{8'h00, 1'b1, 1'b1, 3'd7}},
        '{ACT_VREAD,    3'd0, 8'h00, 1'b1, '{8'h00, 1'b1, 1'b0, 3'd0}},
        '{ACT_DROP,     3'd7, 8'h00, 1'b0, R_IDLE},
        '{ACT_DROP,     3'd0, 8'h00, 1'b0, R_IDLE},
        '{ACT_STATUS,   3'd0, 8'h00, 1'b0, R_IDLE},
        '{ACT_RAISE,    3'd5, 8'h00, 1'b0, R_IDLE},
        '{ACT_STATUS,   3'd0, 8'h05, 1'b0, R_IDLE},  // threshold 2
        '{ACT_POLL,     3'd0, 8'h00, 1'b0, R_IDLE},
        '{ACT_STATUS,   3'd0, 8'h02, 1'b0, R_IDLE},  // threshold 5
        '{ACT_RAISE,    3'd3, 8'h00, 1'b0, R_IDLE},
        '{ACT_POLL,     3'd0, 8'h00, 1'b0, R_IDLE},  // 5 not above 5, stays pending
        '{ACT_VREAD,    3'd0, 8'h00, 1'b0, R_IDLE}
    };

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;

    priority_interrupt_unit_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // model state of the unit
    logic [BYTE_W-1:0]   req_lines;
    logic [BYTE_W-1:0]   status_reg;
    logic                intr_disabled;
    logic [VECTOR_W-1:0] vec_reg;
    logic                intr_line;

    piu_result_t pending_results [$];
    int          mismatch_count;
    int          transfers_in;
    int          transfers_out;
    int          fires_seen;
    int          cycle_count;
    int          burst_left;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic step_interrupt_unit(input logic [2:0] act, input logic [LEVEL_W-1:0] lvl,
                                       input logic [BYTE_W-1:0] din,
                                       output piu_result_t res);
        logic [BYTE_W-1:0]  pending;
        logic [LEVEL_W-1:0] thresh;
        int                 top_lvl;
        res = '0;
        case (act)
            ACT_POLL:
            begin
                pending = ~req_lines;
                if (!intr_disabled && pending != '0)
                begin
                    top_lvl = NUM_LEVELS - 1;
                    while (!pending[top_lvl])
                        top_lvl--;
                    thresh = ~status_reg[LEVEL_W-1:0];
                    if (status_reg[STATUS_ANY] || top_lvl > int'(thresh))
                    begin
                        intr_disabled   = 1'b1;
                        vec_reg         = VECTOR_W'((NUM_LEVELS - 1 - top_lvl) * 8);
                        intr_line       = 1'b1;
                        res.fired       = 1'b1;
                        res.fired_level = LEVEL_W'(top_lvl);
                    end
                end
            end
            ACT_RAISE:  req_lines[lvl] = 1'b0;
            ACT_DROP:   req_lines[lvl] = 1'b1;
            ACT_STATUS:
            begin
                status_reg    = din;
                intr_disabled = 1'b0;
                intr_line     = 1'b0;
            end
            ACT_VREAD:  res.read_data = BYTE_W'(vec_reg);
            default:    ;
        endcase
        res.cpu_interrupt = intr_line;
    endtask

    // random bursts with random gaps; now and then a long burst with no gaps
    task automatic pace_sender();
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
    endtask

    task automatic send_item(input logic [2:0] act, input logic [LEVEL_W-1:0] lvl,
                             input logic [BYTE_W-1:0] din, input logic fixed,
                             input piu_result_t want);
        piu_result_t res;
        pace_sender();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, din, lvl};
        s_axis_tuser  <= act;
        do
            @(posedge clk);
        while (!s_axis_tready);
        step_interrupt_unit(act, lvl, din, res);
        if (res.fired)
            fires_seen++;
        pending_results.push_back(fixed ? want : res);
        transfers_in++;
    endtask

    function automatic logic [2:0] pick_action();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 30) return ACT_POLL;
        if (roll < 50) return ACT_RAISE;
        if (roll < 62) return ACT_DROP;
        if (roll < 77) return ACT_STATUS;
        if (roll < 89) return ACT_VREAD;
        if (roll < 95) return ACT_PREAD;
        return (roll < 97) ? ACT_SPARE_LO : ACT_SPARE_HI;
    endfunction

    // output side stall pattern: modes held for random stretches
    int stall_mode;
    int stall_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_mode    <= 0;
            stall_left    <= 0;
        end
        else
        begin
            if (stall_left == 0)
            begin
                stall_mode <= $urandom_range(0, 3);
                stall_left <= $urandom_range(20, 120);
            end
            else
                stall_left <= stall_left - 1;
            case (stall_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
                2:       m_axis_tready <= ($urandom_range(0, 4) == 0);
                default: m_axis_tready <= ($urandom_range(0, 1) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        piu_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            transfers_out++;
            if (pending_results.size() == 0)
            begin
                $display("[%0t] result transfer with nothing expected", $realtime);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tdata[7:0] != want.read_data)
                    report_mismatch("read_data", m_axis_tdata[7:0], want.read_data);
                if (m_axis_tdata[8] != want.cpu_interrupt)
                    report_mismatch("cpu_interrupt", m_axis_tdata[8], want.cpu_interrupt);
                if (m_axis_tuser != want.fired)
                    report_mismatch("fired", m_axis_tuser, want.fired);
                if (m_axis_tdata[11:9] != want.fired_level)
                    report_mismatch("fired_level", m_axis_tdata[11:9], want.fired_level);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        req_lines      = LINES_RELEASED;
        status_reg     = '0;
        intr_disabled  = 1'b0;
        vec_reg        = '0;
        intr_line      = 1'b0;
        mismatch_count = 0;
        transfers_in   = 0;
        transfers_out  = 0;
        fires_seen     = 0;
        cycle_count    = 0;
        burst_left     = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
            send_item(DIRECTED[i].act, DIRECTED[i].lvl, DIRECTED[i].din,
                      DIRECTED[i].fixed, DIRECTED[i].want);

        // status data is uniform random, so about half the status writes set take-any
        for (int n = 0; n < RANDOM_ITEMS; n++)
            send_item(pick_action(), LEVEL_W'($urandom_range(0, 7)),
                      BYTE_W'($urandom_range(0, 255)), 1'b0, R_IDLE);

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d items sent, %0d results checked, %0d interrupts taken",
                 transfers_in, transfers_out, fires_seen);
        $display("directed table of %0d rows, then %0d random items",
                 NUM_DIRECTED, RANDOM_ITEMS);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
